>>> hw/rtl/fila_pkg.sv
`default_nettype none

package fila_pkg;

  localparam int CMD_W      = 2;
  localparam int SLOT_W     = 9;
  localparam int SIZE_W     = 9;
  localparam int STATUS_W   = 2;
  localparam int GRANT_W    = 8;

  localparam int CAPACITY_DEF = 256;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

  localparam logic [CMD_W-1:0] CMD_POP     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REBUILD = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_DOUBLE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
  } fila_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [GRANT_W-1:0]  granted_slot;
  } fila_out_t;

endpackage

`default_nettype wire

>>> hw/rtl/free_index_list_allocator_core.sv
// Free-list slot allocator. Slot indices are kept as a singly linked list in
// a link memory with a head register.
// Input channel (in_valid, in_stall, in_data): one word carries a command
// (pop, push, rebuild) and, for a push, the slot being returned.
// Result channel (out_valid, out_stall, out_data): exactly one word per
// command with a status and, for a successful pop, the granted slot.
// Configuration: cfg_we writes cfg_wdata into the size register; write it
// only while idle and follow it with a rebuild.
// Timing: a pop or an in-range push reads the link memory, so its result is
// registered from the READ state, or from the RESP state while the output
// register is held, and the next word is taken only once the block is back
// in IDLE. An empty pop, an out-of-range push and the unused command answer
// at the accept edge itself when the output register is free, so a new word
// can be taken straight after. A rebuild walks the link memory one entry per
// cycle; after reset the link memory is initialized by the same kind of walk
// over all entries 0..CAPACITY, and in_stall stays high meanwhile.
// If the receiver stalls, the result stays in the output register; the next
// word is still accepted and its result is held until the register frees.
`default_nettype none

module free_index_list_allocator_core #(
  parameter int CAPACITY = fila_pkg::CAPACITY_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire fila_pkg::fila_in_t        in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output fila_pkg::fila_out_t            out_data,
  input  wire logic                      cfg_we,
  input  wire logic [fila_pkg::SIZE_W-1:0] cfg_wdata
);

  import fila_pkg::*;

  // Address width covers entries 0..CAPACITY, link width also holds the marker.
  localparam int IW = $clog2(CAPACITY + 1);
  localparam int LW = $clog2(CAPACITY + 2);
  localparam int VW = (LW > 10) ? LW : 10;

  typedef enum logic [4:0] {
    ST_INIT = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_READ = 5'b00100,
    ST_FILL = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [IW-1:0]      cnt_r, cnt_nxt;
  logic [LW-1:0]      head_r, head_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [CMD_W-1:0]   op_cmd_r, op_cmd_nxt;
  logic [IW-1:0]      op_slot_r, op_slot_nxt;
  fila_out_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  fila_out_t          out_data_r, out_data_nxt;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [LW-1:0]      ram_wdata;
  logic [IW-1:0]      ram_raddr;
  logic [LW-1:0]      ram_rdata;

  logic [VW-1:0]      size_v, eff_size, head_v, slot_v;
  logic [LW-1:0]      marker;
  logic               in_acc, out_free, fin, load_out;
  fila_out_t          fin_res;

  assign size_v   = VW'(size_r);
  assign eff_size = (size_v > VW'(CAPACITY)) ? VW'(CAPACITY) : size_v;
  assign marker   = LW'(eff_size + VW'(1));
  assign head_v   = VW'(head_r);
  assign slot_v   = VW'(in_data.slot);

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  fila_ram #(
    .WIDTH (LW),
    .DEPTH (CAPACITY + 1)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    head_nxt    = head_r;
    op_cmd_nxt  = op_cmd_r;
    op_slot_nxt = op_slot_r;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = cnt_r;
    ram_wdata   = LW'(VW'(cnt_r) + VW'(1));
    ram_raddr   = head_r[IW-1:0];
    fin         = 1'b0;
    fin_res     = '{status: STATUS_OK, granted_slot: '0};

    case (state_r)
      ST_INIT: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + IW'(1);
        if (VW'(cnt_r) == VW'(CAPACITY)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          op_cmd_nxt  = in_data.cmd;
          op_slot_nxt = slot_v[IW-1:0];
          case (in_data.cmd)
            CMD_POP: begin
              if (head_v >= eff_size) begin
                fin            = 1'b1;
                fin_res.status = STATUS_EMPTY;
              end else begin
                ram_raddr = head_r[IW-1:0];
                state_nxt = ST_READ;
              end
            end
            CMD_PUSH: begin
              if (slot_v >= eff_size) begin
                fin            = 1'b1;
                fin_res.status = STATUS_RANGE;
              end else begin
                ram_raddr = slot_v[IW-1:0];
                state_nxt = ST_READ;
              end
            end
            CMD_REBUILD: begin
              cnt_nxt   = '0;
              head_nxt  = '0;
              state_nxt = ST_FILL;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        fin = 1'b1;
        if (op_cmd_r == CMD_POP) begin
          // Hand out the head, follow its link and mark the slot taken.
          ram_we               = 1'b1;
          ram_waddr            = head_r[IW-1:0];
          ram_wdata            = marker;
          head_nxt             = ram_rdata;
          fin_res.granted_slot = head_v[GRANT_W-1:0];
        end else if (ram_rdata != marker) begin
          fin_res.status = STATUS_DOUBLE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = op_slot_r;
          ram_wdata = head_r;
          head_nxt  = LW'(op_slot_r);
        end
      end
      ST_FILL: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + IW'(1);
        if (VW'(cnt_r) == eff_size) begin
          cnt_nxt = '0;
          fin     = 1'b1;
        end
      end
      ST_RESP: begin
        fin     = 1'b1;
        fin_res = res_r;
      end
      default: begin
        state_nxt = ST_INIT;
        cnt_nxt   = '0;
      end
    endcase

    // A finished result goes straight to the output register when it is free.
    load_out = fin && out_free;
    if (fin) begin
      if (out_free) begin
        state_nxt = ST_IDLE;
      end else begin
        res_nxt   = fin_res;
        state_nxt = ST_RESP;
      end
    end
  end

  assign size_nxt      = cfg_we ? cfg_wdata : size_r;
  assign out_valid_nxt = load_out || (out_valid_r && out_stall);
  assign out_data_nxt  = load_out ? fin_res : out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      head_r      <= '0;
      size_r      <= SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_cmd_r   <= op_cmd_nxt;
    op_slot_r  <= op_slot_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !fin) |=> in_stall)
    else $error("word accepted while a memory access or rebuild is in flight");

  a_grant_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && fin_res.status != STATUS_OK) |-> (fin_res.granted_slot == '0))
    else $error("nonzero granted slot on a failed command");

  a_head_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    VW'(head_r) <= VW'(CAPACITY + 1))
    else $error("head beyond the link table");

  a_pop_marks_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ && op_cmd_r == CMD_POP) |-> (ram_we && ram_wdata == marker))
    else $error("pop did not mark the slot taken");

  a_no_result_during_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> !load_out)
    else $error("result produced during link table initialization");

endmodule

`default_nettype wire

>>> hw/rtl/fila_ram.sv
`default_nettype none

module fila_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 257
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> tb/free_index_list_allocator_core_tb.sv
`timescale 1ns / 1ps

module free_index_list_allocator_core_tb;
  import fila_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int PLAN = 0;
  localparam int LIVE = 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fila_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fila_out_t out_data;
  logic cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  // Two copies of the allocator state: one advanced while words are planned,
  // one advanced as the block accepts them.
  logic [SLOT_W-1:0] link_tab [0:1][0:CAP];
  logic [SLOT_W-1:0] head_reg [0:1];
  logic [SIZE_W-1:0] size_reg [0:1];

  fila_in_t pending_words[$];
  fila_out_t expected_results[$];
  int fail_count = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit send_gaps_on = 1'b1;
  bit recv_stalls_on = 1'b1;

  free_index_list_allocator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int managed_slots(input int c);
    return (size_reg[c] > CAP) ? CAP : int'(size_reg[c]);
  endfunction

  function automatic fila_out_t alloc_predict(input int c, input fila_in_t w);
    fila_out_t r;
    int n;
    int mark;
    int g;
    n = managed_slots(c);
    mark = n + 1;
    r.status = STATUS_OK;
    r.granted_slot = '0;
    case (w.cmd)
      CMD_POP: begin
        if (head_reg[c] >= n) begin
          r.status = STATUS_EMPTY;
        end else begin
          g = head_reg[c];
          r.granted_slot = GRANT_W'(g);
          head_reg[c] = link_tab[c][g];
          link_tab[c][g] = SLOT_W'(mark);
        end
      end
      CMD_PUSH: begin
        if (w.slot >= n) begin
          r.status = STATUS_RANGE;
        end else if (link_tab[c][w.slot] != mark) begin
          r.status = STATUS_DOUBLE;
        end else begin
          link_tab[c][w.slot] = head_reg[c];
          head_reg[c] = w.slot;
        end
      end
      CMD_REBUILD: begin
        for (int i = 0; i <= n; i++) link_tab[c][i] = SLOT_W'(i + 1);
        head_reg[c] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Sender: the next word is loaded once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(alloc_predict(LIVE, in_data));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= pending_words.pop_front();
          send_gap <= send_gaps_on ? draw_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each taken word and stalls at random.
  always @(posedge clk) begin : result_check
    fila_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, got status %0d granted %0d", $time,
                 out_data.status, out_data.granted_slot);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_data.status);
          fail_count++;
        end
        if (out_data.granted_slot !== want.granted_slot) begin
          $display("%0t: granted_slot expected %0d, got %0d", $time, want.granted_slot,
                   out_data.granted_slot);
          fail_count++;
        end
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (recv_stalls_on && $urandom_range(99) < 25) begin
      out_stall <= 1'b1;
      stall_left <= draw_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic plan_word(input logic [CMD_W-1:0] cmd, input int slot);
    fila_in_t w;
    w.cmd = cmd;
    w.slot = SLOT_W'(slot);
    void'(alloc_predict(PLAN, w));
    pending_words.push_back(w);
  endtask

  // A slot that is currently handed out, or -1 when none is.
  function automatic int pick_held_slot();
    int n;
    int held[$];
    n = managed_slots(PLAN);
    for (int i = 0; i < n; i++) if (link_tab[PLAN][i] == n + 1) held.push_back(i);
    if (held.size() == 0) return -1;
    return held[$urandom_range(held.size() - 1)];
  endfunction

  task automatic plan_random_word(input int pop_pct);
    int r;
    int held;
    int n;
    r = $urandom_range(99);
    held = pick_held_slot();
    n = managed_slots(PLAN);
    if (r < pop_pct || (r < 88 && held < 0)) plan_word(CMD_POP, $urandom_range(511));
    else if (r < 88) plan_word(CMD_PUSH, held);
    else if (r < 94) plan_word(CMD_PUSH, $urandom_range(1) ? $urandom_range(511) : $urandom_range(n));
    else if (r < 97) plan_word(CMD_REBUILD, $urandom_range(511));
    else plan_word(CMD_UNUSED, $urandom_range(511));
  endtask

  // Hold off until every word has been answered, then let a full table walk
  // go by so the block is surely idle.
  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (CAP + 8) @(posedge clk);
  endtask

  task automatic set_size(input int size_val);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= SIZE_W'(size_val);
    @(posedge clk);
    cfg_we <= 1'b0;
    size_reg[PLAN] = SIZE_W'(size_val);
    size_reg[LIVE] = SIZE_W'(size_val);
  endtask

  task automatic run_phase(input int size_val, input bit rebuild_first, input int words,
                           input bit idle_on);
    int pop_pct;
    set_size(size_val);
    send_gaps_on = idle_on;
    recv_stalls_on = idle_on;
    pop_pct = $urandom_range(35, 60);
    if (rebuild_first) plan_word(CMD_REBUILD, $urandom_range(511));
    repeat (words) plan_random_word(pop_pct);
  endtask

  initial begin
    int sizes[10];
    sizes = '{256, 1, 2, 37, 511, 5, 0, 200, 3, 256};
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i <= CAP; i++) link_tab[c][i] = SLOT_W'(i + 1);
      head_reg[c] = '0;
      size_reg[c] = SIZE_RESET;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Full size after reset: grants, a good free, a double free, out-of-range
    // frees at the top of the slot field, the unused command and a rebuild.
    plan_word(CMD_POP, 0);
    plan_word(CMD_POP, 511);
    plan_word(CMD_POP, 0);
    plan_word(CMD_PUSH, 1);
    plan_word(CMD_PUSH, 1);
    plan_word(CMD_PUSH, 511);
    plan_word(CMD_PUSH, 256);
    plan_word(CMD_PUSH, 255);
    plan_word(CMD_POP, 0);
    plan_word(CMD_UNUSED, 511);
    plan_word(CMD_REBUILD, 0);
    plan_word(CMD_POP, 0);

    // Shrink without a rebuild: the old head and old taken marks no longer fit.
    set_size(1);
    plan_word(CMD_POP, 0);
    plan_word(CMD_PUSH, 0);
    plan_word(CMD_REBUILD, 0);
    plan_word(CMD_POP, 0);
    plan_word(CMD_POP, 0);
    plan_word(CMD_PUSH, 0);
    plan_word(CMD_PUSH, 1);

    // A size of zero manages no slot at all.
    set_size(0);
    plan_word(CMD_POP, 0);
    plan_word(CMD_PUSH, 0);
    plan_word(CMD_REBUILD, 0);
    plan_word(CMD_POP, 0);

    // A size beyond the capacity is clamped to it.
    set_size(511);
    plan_word(CMD_REBUILD, 0);
    plan_word(CMD_POP, 0);
    plan_word(CMD_PUSH, 0);
    plan_word(CMD_PUSH, 255);
    plan_word(CMD_PUSH, 256);

    foreach (sizes[k]) begin
      run_phase(sizes[k], (k == 0) || ($urandom_range(3) != 0), 65,
                (k != 3) && (k != 8));
    end

    drain();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/fila_pkg.sv
hw/rtl/fila_ram.sv
hw/rtl/free_index_list_allocator_core.sv
tb/free_index_list_allocator_core_tb.sv
